@@ rtl/core/spf_pkg.sv @@
// Shared constants, types and the arctangent table of the scan point flip block.
`default_nettype none
package spf_pkg;
    localparam int INDEX_BITS    = 11;
    localparam int COORD_BITS    = 24;
    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int RANGE_BITS    = 20;
    localparam int SAMPLE_BITS   = 22;
    localparam int DIST_BITS     = RANGE_BITS + 1;
    localparam int MARG_BITS     = RANGE_BITS + 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;
    localparam int CW            = 34;
    localparam int PW            = MARG_BITS + CW;

    localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_ANGLE,
        REG_ANGLE_STEP,
        REG_MAX_RANGE,
        REG_VISIBLE_RANGE,
        REG_FLIP_RADIUS
    } t_reg_idx;

    typedef struct packed {
        logic [DIST_BITS-1:0]        range_d;
        logic signed [MARG_BITS-1:0] marg;
        logic                        zero;
        logic                        scan_end;
    } t_side;

    typedef struct packed {
        logic                 valid;
        t_side                side;
        logic                 neg;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cstage;

    function automatic logic signed [CW-1:0] atan_entry(input int unsigned i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933406;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/spf_in_if.sv @@
// Request channel carrying one range sample.
`default_nettype none
interface spf_in_if import spf_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [INDEX_BITS-1:0]  beam_index;
    logic [SAMPLE_BITS-1:0] range_sample;
    logic                   scan_end;
    modport source (output valid, beam_index, range_sample, scan_end, input ready);
    modport sink (input valid, beam_index, range_sample, scan_end, output ready);
endinterface
`default_nettype wire

@@ rtl/core/spf_out_if.sv @@
// Result channel carrying the raw and flipped point.
`default_nettype none
interface spf_out_if import spf_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] flipped_x;
    logic signed [COORD_BITS-1:0] flipped_y;
    logic                         zero_norm;
    logic                         saturated;
    logic                         scan_end_out;
    modport source (output valid, point_x, point_y, flipped_x, flipped_y, zero_norm,
                    saturated, scan_end_out, input ready);
    modport sink (input valid, point_x, point_y, flipped_x, flipped_y, zero_norm,
                  saturated, scan_end_out, output ready);
endinterface
`default_nettype wire

@@ rtl/core/spf_cfg_if.sv @@
// Configuration write channel.
`default_nettype none
interface spf_cfg_if import spf_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/spf_front.sv @@
// Configuration registers, beam angle, distance selection and drop decision.
`default_nettype none
module spf_front import spf_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    spf_in_if.sink               i_req,
    spf_cfg_if.sink              i_cfg,
    output logic                 o_valid,
    output logic [ANGLE_BITS-1:0] o_angle,
    output t_side                o_side
);
    logic [ANGLE_BITS-1:0] r_start, r_step;
    logic [RANGE_BITS-1:0] r_max, r_vis, r_flip;
    logic                  r_valid;
    logic [ANGLE_BITS-1:0] r_angle;
    t_side                 r_side;

    logic [INDEX_BITS+ANGLE_BITS-1:0] prod;
    logic [SAMPLE_BITS-1:0]           twice;
    logic [DIST_BITS-1:0]             n_dist;
    logic                             drop;
    t_side                            n_side;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = i_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_step  <= ANGLE_BITS'(64);
            r_max   <= RANGE_BITS'(30720);
            r_vis   <= RANGE_BITS'(30720);
            r_flip  <= RANGE_BITS'(102400);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_START_ANGLE:   r_start <= i_cfg.data[ANGLE_BITS-1:0];
                REG_ANGLE_STEP:    r_step  <= i_cfg.data[ANGLE_BITS-1:0];
                REG_MAX_RANGE:     r_max   <= i_cfg.data[RANGE_BITS-1:0];
                REG_VISIBLE_RANGE: r_vis   <= i_cfg.data[RANGE_BITS-1:0];
                REG_FLIP_RADIUS:   r_flip  <= i_cfg.data[RANGE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prod  = i_req.beam_index * r_step;
        twice = {1'b0, r_max, 1'b0};
        drop  = (i_req.range_sample == twice);
        if (i_req.range_sample > twice) begin
            n_dist = {1'b0, (r_vis > r_max) ? r_vis : r_max};
        end else begin
            n_dist = i_req.range_sample[DIST_BITS-1:0];
        end
        n_side.range_d  = n_dist;
        n_side.marg     = $signed({2'b00, r_flip, 1'b0}) - $signed({2'b00, n_dist});
        n_side.zero     = (n_dist == '0);
        n_side.scan_end = i_req.scan_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_req.valid & ~drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= r_start + prod[ANGLE_BITS-1:0];
            r_side  <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;
    assign o_side  = r_side;
endmodule
`default_nettype wire

@@ rtl/core/spf_cordic.sv @@
// Pipelined CORDIC rotation, one iteration per register stage.
`default_nettype none
module spf_cordic import spf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [ANGLE_BITS-1:0] i_angle,
    input  wire t_side            i_side,
    output t_cstage               o_stage
);
    t_cstage r_stg [CORDIC_STAGES];
    t_cstage init;
    logic signed [CW-1:0] z0;

    always_comb begin
        z0 = CW'($signed({i_angle, 16'h0000}));
        init.valid = i_valid;
        init.side  = i_side;
        init.x     = CORDIC_GAIN;
        init.y     = '0;
        init.neg   = 1'b0;
        init.z     = z0;
        if (z0 > QUARTER_TURN) begin
            init.z   = z0 - HALF_TURN;
            init.neg = 1'b1;
        end else if (z0 < -QUARTER_TURN) begin
            init.z   = z0 + HALF_TURN;
            init.neg = 1'b1;
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        t_cstage cur, nxt;
        logic signed [CW-1:0] xs, ys;
        if (g == 0) begin : g_first
            assign cur = init;
        end else begin : g_rest
            assign cur = r_stg[g-1];
        end
        always_comb begin
            xs  = cur.x >>> g;
            ys  = cur.y >>> g;
            nxt = cur;
            if (cur.z >= 0) begin
                nxt.x = cur.x - ys;
                nxt.y = cur.y + xs;
                nxt.z = cur.z - atan_entry(g);
            end else begin
                nxt.x = cur.x + ys;
                nxt.y = cur.y - xs;
                nxt.z = cur.z + atan_entry(g);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[g] <= '0;
            end else if (i_en) begin
                r_stg[g] <= nxt;
            end
        end
    end

    assign o_stage = r_stg[CORDIC_STAGES-1];
endmodule
`default_nettype wire

@@ rtl/core/spf_scale.sv @@
// Scaling multipliers, rounding, saturation and the output register.
`default_nettype none
module spf_scale import spf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_cstage i_stage,
    spf_out_if.source  o_res
);
    localparam logic signed [PW-1:0] HI = PW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] LO = -HI - PW'(1);
    localparam logic signed [PW-1:0] HALF_LSB = PW'(64'sd1 <<< 29);

    logic                 r_mvalid, r_mzero, r_mend;
    logic signed [PW-1:0] r_prd [4];
    logic                 r_valid;
    logic signed [CW-1:0] c, s;
    logic signed [MARG_BITS-1:0] dsig;
    logic signed [PW-1:0] prd [4];
    logic signed [PW-1:0] rnd [4];
    logic [COORD_BITS-1:0] res [4];
    logic [3:0]           hit;

    always_comb begin
        c      = i_stage.neg ? -i_stage.x : i_stage.x;
        s      = i_stage.neg ? -i_stage.y : i_stage.y;
        dsig   = $signed({2'b00, i_stage.side.range_d});
        prd[0] = dsig * c;
        prd[1] = dsig * s;
        prd[2] = i_stage.side.marg * c;
        prd[3] = i_stage.side.marg * s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (i_en) begin
            r_mvalid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mzero  <= i_stage.side.zero;
            r_mend   <= i_stage.side.scan_end;
            r_prd[0] <= prd[0];
            r_prd[1] <= prd[1];
            r_prd[2] <= prd[2];
            r_prd[3] <= prd[3];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rnd[k] = (r_prd[k] + HALF_LSB) >>> 30;
            hit[k] = 1'b0;
            res[k] = rnd[k][COORD_BITS-1:0];
            if (rnd[k] > HI) begin
                res[k] = HI[COORD_BITS-1:0];
                hit[k] = 1'b1;
            end else if (rnd[k] < LO) begin
                res[k] = LO[COORD_BITS-1:0];
                hit[k] = 1'b1;
            end
            if (r_mzero) begin
                res[k] = '0;
                hit[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.point_x      <= res[0];
            o_res.point_y      <= res[1];
            o_res.flipped_x    <= res[2];
            o_res.flipped_y    <= res[3];
            o_res.zero_norm    <= r_mzero;
            o_res.saturated    <= hit[2] | hit[3];
            o_res.scan_end_out <= r_mend;
        end
    end

    assign o_res.valid = r_valid;
endmodule
`default_nettype wire

@@ rtl/core/scan_point_spherical_flip_top.sv @@
// Top level of the scan point spherical flip block.
// The block turns laser range samples into Cartesian points and their
// spherically flipped images. Requests arrive on i_req with a beam index,
// a range and a scan end mark; results leave on o_res. Five registers
// (start angle, angle step, maximum range, visible range, flip radius) are
// written through i_cfg, which is always ready and should be used only while
// the block is idle. A sample equal to twice the maximum range is dropped.
// Every stage is a register stage: one for the angle and distance, sixteen
// CORDIC iterations, one for the multipliers and the output register, 19 in
// all. One request is taken every cycle unless the pipeline holds. When the
// receiver stalls a full output register, the whole pipeline holds and
// i_req.ready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline and restores the register defaults.
`default_nettype none
module scan_point_spherical_flip_top import spf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spf_in_if.sink    i_req,
    spf_cfg_if.sink   i_cfg,
    spf_out_if.source o_res
);
    logic                  en;
    logic                  f_valid;
    logic [ANGLE_BITS-1:0] f_angle;
    t_side                 f_side;
    t_cstage               c_last;

    assign en = ~o_res.valid | o_res.ready;

    spf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_req   (i_req),
        .i_cfg   (i_cfg),
        .o_valid (f_valid),
        .o_angle (f_angle),
        .o_side  (f_side)
    );

    spf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_angle (f_angle),
        .i_side  (f_side),
        .o_stage (c_last)
    );

    spf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (c_last),
        .o_res   (o_res)
    );
endmodule
`default_nettype wire
